// ===== src/pgg_pkg.sv =====
// pgg_pkg: shared types, register codes, command codes and constant tables
// for the portamento glide generator. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pgg_pkg;

    // default parameter values
    localparam int P_PITCH_FRAC_BITS = 16;
    localparam int P_COUNT_BITS      = 22;

    // configuration port
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE  = 2'd3;

    // command codes
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_JUMP   = 3'd1;
    localparam logic [2:0] FN_START  = 3'd2;
    localparam logic [2:0] FN_ORIGIN = 3'd3;
    localparam logic [2:0] FN_TARGET = 3'd4;
    localparam logic [2:0] FN_SNAP   = 3'd5;

    // divider width
    localparam int DIV_W = 32;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [23:0] pitch_a;
        logic signed [23:0] pitch_b;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] pitch_now;
        logic [16:0]        glide_progress;
        logic               is_gliding;
    } t_out_word;

    typedef struct packed {
        logic               mode;
        logic [21:0]        length;
        logic [24:0]        step;
        logic signed [9:0]  curve;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;

    typedef logic [15:0][29:0] t_base_tab;

    // floor square root, used only to build the constant table
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bt;
        x  = v;
        r  = '0;
        bt = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // successive square roots of one half in Q30, entry i weighs bit i
    function automatic t_base_tab f_base_tab();
        logic [63:0] b;
        t_base_tab   t;
        b = 64'd1 << 29;
        t = '0;
        for (int i = 15; i >= 0; i--) begin
            b    = f_isqrt(b << 30);
            t[i] = b[29:0];
        end
        return t;
    endfunction

    localparam t_base_tab EXP_BASE = f_base_tab();

    // index of the highest set bit
    function automatic logic [4:0] f_msb(input logic [31:0] x);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 5'(i);
        end
        return n;
    endfunction

    // magnitude of a pitch difference
    function automatic logic [24:0] f_abs25(input logic signed [24:0] v);
        logic [24:0] m;
        m = v[24] ? 25'(-v) : 25'(v);
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== src/pgg_div.sv =====
// pgg_div: restoring fraction divider, one quotient bit per cycle, 16 bits.
// Numerator must be below the divisor. Depends on pgg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgg_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pgg_pkg::t_div_req i_req,
    output pgg_pkg::t_div_rsp      o_rsp
);
    import pgg_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [15:0]      r_quo;
    logic [DIV_W:0]   w_sh;
    logic             w_ge;

    // shift and trial subtract
    assign w_sh = {r_rem, 1'b0};
    assign w_ge = w_sh >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DIV_W'(w_sh - {1'b0, r_den});
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= w_sh[DIV_W-1:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// ===== src/pgg_engine.sv =====
// pgg_engine: command sequencer with one shared 32x32 multiplier that runs
// the analog step, log2 squaring, exp2 products, curve scaling and pitch scaling.
// Depends on pgg_pkg; uses pgg_div results for progress.
`timescale 1ns / 1ps
`default_nettype none
module pgg_engine #(
    parameter int PITCH_FRAC_BITS = pgg_pkg::P_PITCH_FRAC_BITS,
    parameter int COUNT_BITS      = pgg_pkg::P_COUNT_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire pgg_pkg::t_in_word  i_item,
    input  wire pgg_pkg::t_cfg      i_cfg,
    output logic                    o_idle,
    output logic                    o_res_valid,
    output pgg_pkg::t_out_word      o_res,
    input  wire logic               i_res_take,
    output pgg_pkg::t_div_req       o_div_req,
    input  wire pgg_pkg::t_div_rsp  i_div_rsp
);
    import pgg_pkg::*;

    localparam logic [63:0] ONE_PITCH = 64'd1 << PITCH_FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] TC_MAX = '1;
    localparam logic [16:0] PROG_FULL = 17'd65536;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CMD   = 15'b000000000000010,
        S_BEGIN = 15'b000000000000100,
        S_ASTEP = 15'b000000000001000,
        S_ASNAP = 15'b000000000010000,
        S_EXP   = 15'b000000000100000,
        S_EXPSH = 15'b000000001000000,
        S_LOGI  = 15'b000000010000000,
        S_LOG   = 15'b000000100000000,
        S_LOGE  = 15'b000001000000000,
        S_YM    = 15'b000010000000000,
        S_PITCH = 15'b000100000000000,
        S_PROG  = 15'b001000000000000,
        S_DIV   = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]             r_func, n_func;
    logic signed [23:0]     r_pa, n_pa;
    logic signed [23:0]     r_pb, n_pb;
    logic signed [23:0]     r_start, n_start;
    logic signed [23:0]     r_target, n_target;
    logic signed [23:0]     r_cur, n_cur;
    logic [COUNT_BITS-1:0]  r_tc, n_tc;
    logic                   r_active, n_active;
    logic [16:0]            r_prog, n_prog;
    logic [30:0]            r_exp_r, n_exp_r;
    logic [25:0]            r_exp_m, n_exp_m;
    logic                   r_phase, n_phase;
    logic [3:0]             r_bit, n_bit;
    logic [18:0]            r_k16, n_k16;
    logic [16:0]            r_s, n_s;
    logic [31:0]            r_mant, n_mant;
    logic [15:0]            r_frac, n_frac;
    logic [4:0]             r_lg_n, n_lg_n;
    logic                   r_lsel, n_lsel;
    logic [20:0]            r_la, n_la;
    logic [20:0]            r_lp, n_lp;

    // pitch differences
    logic signed [24:0] w_d_tc, w_d_ts;
    logic [24:0]        w_m_tc, w_m_ts;
    logic [24:0]        w_step;
    assign w_d_tc = 25'(r_target) - 25'(r_cur);
    assign w_d_ts = 25'(r_target) - 25'(r_start);
    assign w_m_tc = f_abs25(w_d_tc);
    assign w_m_ts = f_abs25(w_d_ts);
    assign w_step = (i_cfg.step > 25'(1 << 24)) ? 25'(1 << 24) : i_cfg.step;

    // shared multiplier
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_ASTEP: begin
                w_mul_a = 32'(w_m_tc);
                w_mul_b = 32'(w_step);
            end
            S_EXP: begin
                w_mul_a = 32'(r_exp_r);
                w_mul_b = 32'(EXP_BASE[r_bit]);
            end
            S_LOG: begin
                w_mul_a = r_mant;
                w_mul_b = r_mant;
            end
            S_YM: begin
                w_mul_a = 32'(r_k16);
                w_mul_b = 32'(r_lp);
            end
            S_PITCH: begin
                w_mul_a = 32'(w_m_ts);
                w_mul_b = 32'(r_s);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // rounded product views
    logic [63:0] w_r24, w_r16, w_r29;
    logic [24:0] w_q24, w_q16;
    logic [30:0] w_exp_step;
    logic [32:0] w_sq;
    logic [25:0] w_ym;
    assign w_r24      = w_prod + 64'(1 << 23);
    assign w_r16      = w_prod + 64'(1 << 15);
    assign w_r29      = w_prod + 64'(1 << 29);
    assign w_q24      = w_r24[48:24];
    assign w_q16      = w_r16[40:16];
    assign w_exp_step = w_r29[60:30];
    assign w_sq       = w_prod[63:31];
    assign w_ym       = w_r16[41:16];

    // exp2 integer shift with rounding
    logic [9:0]  w_ip;
    logic [5:0]  w_sh;
    logic [30:0] w_shr;
    logic [31:0] w_shr1;
    logic [30:0] w_e;
    logic [31:0] w_k_sum, w_s_sum;
    assign w_ip   = r_exp_m[25:16];
    assign w_sh   = w_ip[5:0] - 6'd1;
    assign w_shr  = r_exp_r >> w_sh;
    assign w_shr1 = 32'(w_shr) + 32'd1;
    always_comb begin
        if (w_ip > 10'd40) begin
            w_e = '0;
        end else if (w_ip == 10'd0) begin
            w_e = r_exp_r;
        end else begin
            w_e = w_shr1[31:1];
        end
    end
    assign w_k_sum = 32'(w_e) + 32'd2048;
    assign w_s_sum = 32'(w_e) + 32'd8192;

    // tick counter advance and end test
    logic [COUNT_BITS-1:0] w_tc_inc;
    logic                  w_t_end;
    assign w_tc_inc = (r_tc != TC_MAX) ? r_tc + 1'b1 : r_tc;
    assign w_t_end  = (i_cfg.length == 22'd0) ||
                      (32'(w_tc_inc) >= 32'(i_cfg.length)) || (w_tc_inc == TC_MAX);

    // curve exponent argument
    logic signed [9:0]  w_c;
    logic signed [19:0] w_cm;
    always_comb begin
        if (i_cfg.curve < -10'sd256) begin
            w_c = -10'sd256;
        end else if (i_cfg.curve > 10'sd256) begin
            w_c = 10'sd256;
        end else begin
            w_c = i_cfg.curve;
        end
    end
    assign w_cm = 20'sd131072 + (20'(w_c) <<< 9);

    // log normalization
    logic [31:0] w_lx;
    logic [4:0]  w_ln;
    logic [20:0] w_lval;
    assign w_lx   = r_lsel ? 32'(r_tc) : 32'(i_cfg.length);
    assign w_ln   = f_msb(w_lx);
    assign w_lval = {r_lg_n, r_frac};

    // begin-glide test
    logic w_differ;
    assign w_differ = (64'(w_m_ts) * 64'd1000000) > ONE_PITCH;

    // analog step result
    logic signed [24:0] w_a_new;
    assign w_a_new = w_d_tc[24] ? 25'(r_cur) - 25'(w_q24) : 25'(r_cur) + 25'(w_q24);

    // timed pitch result
    logic signed [24:0] w_t_new;
    assign w_t_new = w_d_ts[24] ? 25'(r_start) - 25'(w_q16) : 25'(r_start) + 25'(w_q16);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_start  = r_start;
        n_target = r_target;
        n_cur    = r_cur;
        n_tc     = r_tc;
        n_active = r_active;
        n_prog   = r_prog;
        n_exp_r  = r_exp_r;
        n_exp_m  = r_exp_m;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_k16    = r_k16;
        n_s      = r_s;
        n_mant   = r_mant;
        n_frac   = r_frac;
        n_lg_n   = r_lg_n;
        n_lsel   = r_lsel;
        n_la     = r_la;
        n_lp     = r_lp;
        o_div_req.start = 1'b0;
        o_div_req.num   = '0;
        o_div_req.den   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func  = i_item.func;
                    n_pa    = i_item.pitch_a;
                    n_pb    = i_item.pitch_b;
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_state = S_PROG;
                case (r_func)
                    FN_TICK: begin
                        if (r_active) begin
                            if (i_cfg.mode) begin
                                n_state = S_ASTEP;
                            end else begin
                                n_tc = w_tc_inc;
                                if (w_t_end) begin
                                    n_cur    = r_target;
                                    n_active = 1'b0;
                                end else begin
                                    n_exp_m = 26'(unsigned'(w_cm));
                                    n_exp_r = 31'(1 << 30);
                                    n_bit   = 4'd15;
                                    n_phase = 1'b0;
                                    n_state = S_EXP;
                                end
                            end
                        end
                    end
                    FN_JUMP: begin
                        n_start  = r_pa;
                        n_target = r_pa;
                        n_cur    = r_pa;
                        n_tc     = '0;
                        n_active = 1'b0;
                    end
                    FN_START: begin
                        n_start  = r_pa;
                        n_cur    = r_pa;
                        n_target = r_pb;
                        n_state  = S_BEGIN;
                    end
                    FN_ORIGIN: begin
                        n_start = r_pa;
                        n_cur   = r_pa;
                        n_state = S_BEGIN;
                    end
                    FN_TARGET: begin
                        n_start  = r_cur;
                        n_target = r_pa;
                        n_state  = S_BEGIN;
                    end
                    FN_SNAP: begin
                        n_cur    = r_target;
                        n_active = 1'b0;
                    end
                    default: begin
                        n_state = S_PROG;
                    end
                endcase
            end
            S_BEGIN: begin
                n_tc     = '0;
                n_active = w_differ && (i_cfg.mode || (i_cfg.length != 22'd0));
                if (!n_active) n_cur = r_target;
                n_state  = S_PROG;
            end
            S_ASTEP: begin
                n_cur   = w_a_new[23:0];
                n_state = S_ASNAP;
            end
            S_ASNAP: begin
                if ((64'(w_m_tc) * 64'd1000) < ONE_PITCH) begin
                    n_cur    = r_target;
                    n_active = 1'b0;
                end
                n_state = S_PROG;
            end
            S_EXP: begin
                if (r_exp_m[r_bit]) n_exp_r = w_exp_step;
                if (r_bit == 4'd0) begin
                    n_state = S_EXPSH;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            S_EXPSH: begin
                if (!r_phase) begin
                    n_k16   = w_k_sum[30:12];
                    n_lsel  = 1'b0;
                    n_state = S_LOGI;
                end else begin
                    n_s     = w_s_sum[30:14];
                    n_state = S_PITCH;
                end
            end
            S_LOGI: begin
                n_lg_n  = w_ln;
                n_mant  = w_lx << (5'd31 - w_ln);
                n_frac  = '0;
                n_bit   = 4'd15;
                n_state = S_LOG;
            end
            S_LOG: begin
                if (w_sq[32]) begin
                    n_mant        = w_sq[32:1];
                    n_frac[r_bit] = 1'b1;
                end else begin
                    n_mant = w_sq[31:0];
                end
                if (r_bit == 4'd0) begin
                    n_state = S_LOGE;
                end else begin
                    n_bit = r_bit - 4'd1;
                end
            end
            S_LOGE: begin
                if (!r_lsel) begin
                    n_la    = w_lval;
                    n_lsel  = 1'b1;
                    n_state = S_LOGI;
                end else begin
                    n_lp    = r_la - w_lval;
                    n_state = S_YM;
                end
            end
            S_YM: begin
                n_exp_m = w_ym;
                n_exp_r = 31'(1 << 30);
                n_bit   = 4'd15;
                n_phase = 1'b1;
                n_state = S_EXP;
            end
            S_PITCH: begin
                n_cur   = w_t_new[23:0];
                n_state = S_PROG;
            end
            S_PROG: begin
                n_state = S_DONE;
                if (!r_active) begin
                    n_prog = PROG_FULL;
                end else if (i_cfg.mode) begin
                    if ((64'(w_m_ts) * 64'd1000000) <= ONE_PITCH) begin
                        n_prog = PROG_FULL;
                    end else if (w_m_tc >= w_m_ts) begin
                        n_prog = '0;
                    end else begin
                        o_div_req.start = 1'b1;
                        o_div_req.num   = DIV_W'(w_m_tc);
                        o_div_req.den   = DIV_W'(w_m_ts);
                        n_state         = S_DIV;
                    end
                end else if ((i_cfg.length == 22'd0) ||
                             (32'(r_tc) >= 32'(i_cfg.length))) begin
                    n_prog = PROG_FULL;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_W'(r_tc);
                    o_div_req.den   = DIV_W'(i_cfg.length);
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_prog  = i_cfg.mode ? PROG_FULL - {1'b0, i_div_rsp.quo}
                                         : {1'b0, i_div_rsp.quo};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= '0;
            r_target <= '0;
            r_cur    <= '0;
            r_tc     <= '0;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_target <= n_target;
            r_cur    <= n_cur;
            r_tc     <= n_tc;
            r_active <= n_active;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_prog  <= n_prog;
        r_exp_r <= n_exp_r;
        r_exp_m <= n_exp_m;
        r_phase <= n_phase;
        r_bit   <= n_bit;
        r_k16   <= n_k16;
        r_s     <= n_s;
        r_mant  <= n_mant;
        r_frac  <= n_frac;
        r_lg_n  <= n_lg_n;
        r_lsel  <= n_lsel;
        r_la    <= n_la;
        r_lp    <= n_lp;
    end

    assign o_idle               = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.pitch_now      = r_cur;
    assign o_res.glide_progress = r_prog;
    assign o_res.is_gliding     = r_active;

endmodule
`default_nettype wire

// ===== src/portamento_glide_generator_top.sv =====
// portamento_glide_generator_top: configuration registers, input handshake
// and output word register around the glide engine and divider.
// Depends on pgg_pkg, pgg_engine and pgg_div.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | i_in_valid/o_in_ready | i_in_word (t_in_word)
//  out     | output    | o_out_valid/i_out_ready | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// A timed-mode tick runs two 16-step exp2 passes and two 16-step log2 passes
// on the shared multiplier, then a divide for progress; the next input word
// is accepted only once the engine has finished and returned to idle.
// Reset is synchronous, active low; the state clears to zero, not gliding.
// The next word is accepted while a finished word waits in the output
// register; the engine holds its result until that register frees up.
`timescale 1ns / 1ps
`default_nettype none
module portamento_glide_generator_top #(
    parameter int PITCH_FRAC_BITS = pgg_pkg::P_PITCH_FRAC_BITS,
    parameter int COUNT_BITS      = pgg_pkg::P_COUNT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire pgg_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pgg_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [pgg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pgg_pkg::CFG_W-1:0]         i_cfg_data
);
    import pgg_pkg::*;

    t_cfg      r_cfg;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;
    t_out_word w_res;
    logic      w_idle;
    logic      w_res_valid;
    logic      w_take;
    logic      r_out_valid;
    t_out_word r_out_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= 1'b0;
            r_cfg.length <= '0;
            r_cfg.step   <= 25'(1 << 24);
            r_cfg.curve  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                CFG_LENGTH: r_cfg.length <= i_cfg_data[21:0];
                CFG_STEP:   r_cfg.step   <= i_cfg_data[24:0];
                CFG_CURVE:  r_cfg.curve  <= i_cfg_data[9:0];
                default:    r_cfg.mode   <= r_cfg.mode;
            endcase
        end
    end

    assign o_in_ready = w_idle;

    pgg_engine #(
        .PITCH_FRAC_BITS (PITCH_FRAC_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid & w_idle),
        .i_item      (i_in_word),
        .i_cfg       (r_cfg),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    pgg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // output word register
    assign w_take = w_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_out_word <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for portamento_glide_generator_top.
// Depends on pgg_pkg; a glide predictor in a scoreboard class checks every output word.
`timescale 1ns / 1ps
`default_nettype none

// glide predictor and queue of expected output words
class glide_scoreboard;
    bit              mode;
    bit [21:0]       length;
    bit [24:0]       step;
    int              curve;
    int              start_p;
    int              target_p;
    int              cur_p;
    int unsigned     ticks;
    bit              active;
    pgg_pkg::t_out_word expected_words[$];
    int              errors;

    function new();
        mode = 0; length = 0; step = 25'd1 << 24; curve = 0;
        start_p = 0; target_p = 0; cur_p = 0; ticks = 0; active = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [pgg_pkg::CFG_IDX_W-1:0] idx, logic [24:0] val);
        case (idx)
            pgg_pkg::CFG_MODE:   mode = val[0];
            pgg_pkg::CFG_LENGTH: length = val[21:0];
            pgg_pkg::CFG_STEP:   step = val;
            pgg_pkg::CFG_CURVE:  curve = $signed(val[9:0]);
            default: ;
        endcase
    endfunction

    function int wrap24(longint v);
        logic [23:0] t;
        t = v[23:0];
        return $signed(t);
    endfunction

    function longint unsigned pitch_gap(int a, int b);
        longint d;
        d = longint'(a) - longint'(b);
        return d < 0 ? -d : d;
    endfunction

    function bit far_apart(int a, int b);
        return pitch_gap(a, b) * 1000000 > 65536;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // log2 in Q16 by repeated squaring of the mantissa
    function longint unsigned log2_fx(int unsigned x);
        int n;
        longint unsigned mant, frac;
        n = 31;
        frac = 0;
        while (n > 0 && x[n] == 0) n--;
        mant = longint'(x) << (31 - n);
        for (int i = 15; i >= 0; i--) begin
            mant = (mant * mant) >> 31;
            if (mant >= (64'd1 << 32)) begin
                mant = mant >> 1;
                frac |= 64'd1 << i;
            end
        end
        return (longint'(n) << 16) | frac;
    endfunction

    // 2^(-m/65536) in Q30
    function longint unsigned exp2_neg(longint unsigned m);
        longint unsigned r, base, ip;
        r = 64'd1 << 30;
        base = 64'd1 << 29;
        ip = m >> 16;
        for (int i = 15; i >= 0; i--) begin
            base = floor_sqrt(base << 30);
            if (m[i]) r = (r * base + (64'd1 << 29)) >> 30;
        end
        if (ip > 40) return 0;
        if (ip > 0) r = (r + (64'd1 << (ip - 1))) >> ip;
        return r;
    endfunction

    function longint scaled(longint d, longint unsigned mul, int sh);
        longint unsigned q;
        q = ((d < 0 ? -d : d) * mul + (64'd1 << (sh - 1))) >> sh;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void glide_begin();
        ticks = 0;
        active = far_apart(start_p, target_p) && (mode || length > 0);
        if (!active) cur_p = target_p;
    endfunction

    function void land();
        cur_p = target_p;
        active = 0;
    endfunction

    function void advance();
        longint unsigned st, k16, lp, ym, s;
        int c;
        if (!active) return;
        if (mode) begin
            st = step > (25'd1 << 24) ? (64'd1 << 24) : step;
            cur_p = wrap24(cur_p + scaled(longint'(target_p) - cur_p, st, 24));
            if (pitch_gap(target_p, cur_p) * 1000 < 65536) land();
            return;
        end
        if (ticks < 22'h3FFFFF) ticks++;
        if (length == 0 || ticks >= length || ticks >= 22'h3FFFFF) begin
            land();
            return;
        end
        c = curve < -256 ? -256 : (curve > 256 ? 256 : curve);
        k16 = (exp2_neg(longint'(131072 + c * 512)) * 4 + (64'd1 << 13)) >> 14;
        lp = log2_fx(length) - log2_fx(ticks);
        ym = (k16 * lp + (64'd1 << 15)) >> 16;
        s = (exp2_neg(ym) + (64'd1 << 13)) >> 14;
        cur_p = wrap24(start_p + scaled(longint'(target_p) - start_p, s, 16));
    endfunction

    function longint unsigned progress();
        longint unsigned span, q;
        if (!active) return 65536;
        if (mode) begin
            span = pitch_gap(target_p, start_p);
            if (span * 1000000 <= 65536) return 65536;
            q = (pitch_gap(target_p, cur_p) << 16) / span;
            return q >= 65536 ? 0 : 65536 - q;
        end
        if (length == 0 || ticks >= length) return 65536;
        return (longint'(ticks) << 16) / length;
    endfunction

    // accepted input word: update state and queue the expected output
    function void note_input(pgg_pkg::t_in_word w);
        pgg_pkg::t_out_word e;
        case (w.func)
            pgg_pkg::FN_TICK: advance();
            pgg_pkg::FN_JUMP: begin
                start_p = w.pitch_a; target_p = w.pitch_a; cur_p = w.pitch_a;
                ticks = 0; active = 0;
            end
            pgg_pkg::FN_START: begin
                start_p = w.pitch_a; cur_p = w.pitch_a; target_p = w.pitch_b;
                glide_begin();
            end
            pgg_pkg::FN_ORIGIN: begin
                start_p = w.pitch_a; cur_p = w.pitch_a;
                glide_begin();
            end
            pgg_pkg::FN_TARGET: begin
                start_p = cur_p; target_p = w.pitch_a;
                glide_begin();
            end
            pgg_pkg::FN_SNAP: land();
            default: ;
        endcase
        e.pitch_now = cur_p[23:0];
        e.glide_progress = 17'(progress());
        e.is_gliding = active;
        expected_words.push_back(e);
    endfunction

    // accepted output word: compare with the oldest expectation
    function void check_result(pgg_pkg::t_out_word got);
        pgg_pkg::t_out_word e;
        if (expected_words.size() == 0) begin
            $error("unexpected output word %h", got);
            errors++;
            return;
        end
        e = expected_words.pop_front();
        if (got.pitch_now !== e.pitch_now) begin
            $error("pitch_now expected %h actual %h", e.pitch_now, got.pitch_now);
            errors++;
        end
        if (got.glide_progress !== e.glide_progress) begin
            $error("glide_progress expected %0d actual %0d",
                   e.glide_progress, got.glide_progress);
            errors++;
        end
        if (got.is_gliding !== e.is_gliding) begin
            $error("is_gliding expected %b actual %b", e.is_gliding, got.is_gliding);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import pgg_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_word            o_out_word;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    glide_scoreboard sb;
    bit              calm;

    portamento_glide_generator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // result side: random stalls, checked at the rising edge
    initial begin
        i_out_ready = 0;
        @(negedge i_clk);
        forever begin
            i_out_ready = 1;
            @(negedge i_clk);
            if (gap_len() > 0) begin
                i_out_ready = 0;
                repeat (gap_len()) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_word);
    end

    // drive one word, wait for acceptance, then an optional gap
    task automatic send_word(logic [2:0] fn, logic [23:0] pa, logic [23:0] pb);
        int g;
        i_in_valid = 1;
        i_in_word.func = fn;
        i_in_word.pitch_a = pa;
        i_in_word.pitch_b = pb;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(i_in_word);
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_in_valid = 0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (sb.expected_words.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [24:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    function automatic logic [23:0] rand_pitch();
        int r;
        r = $urandom_range(9);
        if (r < 4) return 24'($urandom);
        if (r < 6) return 24'(sb.cur_p + $signed($urandom_range(128)) - 64);
        return 24'($signed($urandom_range(24 << 16)) - (12 << 16));
    endfunction

    // mostly glides with ticks, with other commands mixed in
    task automatic random_item();
        int r;
        logic [2:0] fn;
        r = $urandom_range(99);
        if (r < 58)      fn = FN_TICK;
        else if (r < 72) fn = FN_START;
        else if (r < 77) fn = FN_JUMP;
        else if (r < 84) fn = FN_ORIGIN;
        else if (r < 92) fn = FN_TARGET;
        else if (r < 97) fn = FN_SNAP;
        else             fn = 3'($urandom_range(7, 6));
        send_word(fn, rand_pitch(), rand_pitch());
    endtask

    initial begin
        logic [21:0] lengths[8];
        logic [24:0] steps[8];
        logic [9:0]  curves[8];
        sb = new();
        calm = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: extremes, every command, idle ticks, unused codes
        send_word(FN_TICK, 24'h0, 24'h0);
        send_word(FN_JUMP, 24'h7FFFFF, 24'h800000);
        send_word(FN_JUMP, 24'h800000, 24'h7FFFFF);
        send_word(FN_START, 24'h800000, 24'h7FFFFF);
        send_word(3'd6, 24'hFFFFFF, 24'hFFFFFF);
        send_word(3'd7, 24'h123456, 24'h654321);
        send_word(FN_SNAP, 24'h0, 24'h0);
        drain();
        write_reg(CFG_LENGTH, 25'd4);
        write_reg(CFG_CURVE, 25'h1FF);
        send_word(FN_START, 24'h800000, 24'h7FFFFF);
        repeat (5) send_word(FN_TICK, 24'h0, 24'h0);
        send_word(FN_START, 24'h0, 24'h20000);
        send_word(FN_TICK, 24'h0, 24'h0);
        send_word(FN_TARGET, 24'hFE0000, 24'h0);
        send_word(FN_ORIGIN, 24'h050000, 24'h0);
        send_word(FN_TICK, 24'h0, 24'h0);
        drain();
        write_reg(CFG_LENGTH, 25'd0);
        send_word(FN_TICK, 24'h0, 24'h0);
        drain();
        write_reg(CFG_MODE, 25'd1);
        write_reg(CFG_STEP, 25'h1FFFFFF);
        write_reg(CFG_CURVE, 25'h200);
        send_word(FN_START, 24'h000000, 24'h7FFFFF);
        send_word(FN_TICK, 24'h0, 24'h0);
        send_word(FN_START, 24'h000000, 24'h000020);
        send_word(FN_TICK, 24'h0, 24'h0);
        drain();

        // random phases through many settings
        lengths = '{22'd1, 22'd2, 22'd5, 22'd17, 22'd0, 22'd64, 22'h3FFFFF, 22'd9};
        steps = '{25'd0, 25'd1, 25'h1000000, 25'h1FFFFFF, 25'h0400000, 25'h0080000,
                  25'h0C00000, 25'h1000001};
        curves = '{10'h100, 10'h300, 10'h000, 10'h1FF, 10'h200, 10'h040, 10'h3C0, 10'h080};
        for (int p = 0; p < 16; p++) begin
            calm = (p % 5 == 3);
            write_reg(CFG_MODE, 25'(p % 3 == 1));
            write_reg(CFG_LENGTH, 25'(p < 8 ? lengths[p] : 22'($urandom_range(40))));
            write_reg(CFG_STEP, p < 8 ? steps[p] : 25'($urandom_range(25'h1000000)));
            write_reg(CFG_CURVE, 25'(p < 8 ? curves[p] : 10'($urandom_range(1023))));
            repeat (70) random_item();
            // leave a glide under way across the next setting change
            send_word(FN_START, rand_pitch(), rand_pitch());
            drain();
        end

        calm = 0;
        drain();
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== portamento_glide_generator_top.f =====
src/pgg_pkg.sv
src/pgg_div.sv
src/pgg_engine.sv
src/portamento_glide_generator_top.sv
dv/tb_top.sv
